[sv/assert_macros.svh]
// Assertion macros used by the RTL of the trilinear interpolator.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Clocked check that also covers the reset cycles.
`define ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_RST(name, prop, msg)
`endif
`endif

[sv/pgti_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the periodic grid interpolator.
// No dependencies.
package pgti_pkg;

    localparam int GRID_DIM   = 16;
    localparam int IDX_BITS   = $clog2(GRID_DIM);
    localparam int ADDR_BITS  = 3 * IDX_BITS;
    localparam int GRID_DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int VALUE_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int POS_BITS   = 24;
    localparam int COEF_BITS  = 18;
    localparam int ROW_BITS   = 3 * COEF_BITS;
    localparam int CELL_BITS  = 5;
    localparam int WRAP_BITS  = 32;
    localparam int CFG_ADDR_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ROW_A   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ROW_B   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ROW_C   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CELLS_X = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CELLS_Y = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CELLS_Z = 3'd5;

    localparam logic [ROW_BITS-1:0] ROW_A_RST = ROW_BITS'(65536);
    localparam logic [ROW_BITS-1:0] ROW_B_RST = ROW_BITS'(65536) << COEF_BITS;
    localparam logic [ROW_BITS-1:0] ROW_C_RST = ROW_BITS'(65536) << (2 * COEF_BITS);

    typedef logic [2:0][POS_BITS-1:0] pos_vec_t;

    // Stage enables of the coordinate pipe: products, sum, scale
    typedef struct packed {
        logic prod;
        logic sum;
        logic scale;
    } coord_en_t;

    // Stage enables of one blend unit: product, finish
    typedef struct packed {
        logic mul;
        logic fin;
    } lerp_en_t;

    function automatic logic [CELL_BITS-1:0] cell_clamp(input logic [CELL_BITS-1:0] n);
        logic [CELL_BITS-1:0] r;
        r = n;
        if (n == '0) r = CELL_BITS'(1);
        else if (n > CELL_BITS'(GRID_DIM)) r = CELL_BITS'(GRID_DIM);
        return r;
    endfunction

endpackage

[sv/periodic_grid_trilinear_interp.sv]
`timescale 1ns / 1ps
// Top level of the periodic grid trilinear interpolator.
// Depends on pgti_pkg, pgti_coord, pgti_ram, pgti_lerp and assert_macros.svh.
//
// Usage:
//   s_ channel carries one word per item. s_tuser = 0 loads a grid entry
//   (load_ix/iy/iz, load_value); s_tuser = 1 queries a Cartesian point.
//   m_ channel returns one interpolated value per query; loads return nothing.
//   cfg_wr_en/cfg_addr/cfg_wdata write the matrix rows (0..2) and cell
//   counts (3..5); write them only while no query is in flight.
// Throughput: one word per cycle while the receiver keeps up; eleven
//   register stages (input, products, sum, scale, grid read, then two
//   stages for each of the three blends).
//   Eight copies of the grid store give the eight corner reads per cycle.
// Loads write all copies at the grid read stage, in order with queries, so a
//   query always sees every load accepted before it.
// Reset empties the pipe and sets the identity matrix and one cell per axis;
//   grid entries are undefined until loaded.
// Receiver stall: each stage holds only while its successor is full, so the
//   block keeps taking words until every stage holds an item.
`include "assert_macros.svh"
module periodic_grid_trilinear_interp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: load_ix[3:0] load_iy[7:4] load_iz[11:8] load_value[35:12]
    //        pos_x[59:36] pos_y[83:60] pos_z[107:84], zero fill to 112
    input  logic [111:0]                        s_tdata,
    // tuser: mode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: interp_value[23:0]
    output logic [pgti_pkg::VALUE_BITS-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [pgti_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [pgti_pkg::ROW_BITS-1:0]       cfg_wdata
);
    localparam int NSTG = 11;
    localparam int IB   = pgti_pkg::IDX_BITS;
    localparam int VB   = pgti_pkg::VALUE_BITS;
    localparam int FB   = pgti_pkg::FRAC_BITS;
    localparam int PB   = pgti_pkg::POS_BITS;

    logic [pgti_pkg::ROW_BITS-1:0]  row_reg [3];
    logic [pgti_pkg::CELL_BITS-1:0] cells_reg [3];

    logic [NSTG:1] vld_reg, vld_next, rdy;

    // stages 1..4 carry the word's own fields
    logic [4:1]          mode_reg;
    logic [IB-1:0]       ix_reg [4:1];
    logic [IB-1:0]       iy_reg [4:1];
    logic [IB-1:0]       iz_reg [4:1];
    logic [VB-1:0]       val_reg [4:1];
    pgti_pkg::pos_vec_t  pos_reg;

    logic [FB-1:0] offy_reg [7:5];
    logic [FB-1:0] offz_reg [9:5];

    logic [IB-1:0]                  idx [3];
    logic [IB-1:0]                  nxt [3];
    logic [FB-1:0]                  off [3];
    logic [pgti_pkg::CELL_BITS-1:0] cnt [3];

    pgti_pkg::coord_en_t coord_en;
    pgti_pkg::lerp_en_t  lx_en, ly_en, lz_en;

    logic                           ram_we, ram_re;
    logic [pgti_pkg::ADDR_BITS-1:0] ram_waddr;
    logic [pgti_pkg::ADDR_BITS-1:0] ram_raddr [8];
    logic signed [VB-1:0]           corner [8];
    logic signed [VB-1:0]           cx [4];
    logic signed [VB-1:0]           cy [2];
    logic signed [VB-1:0]           cz;

    // ready chain: a stage takes a word when it is empty or its successor takes
    always_comb begin
        rdy[NSTG] = m_tready || !vld_reg[NSTG];
        for (int i = NSTG - 1; i >= 1; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[1] = rdy[1] ? s_tvalid : vld_reg[1];
        for (int i = 2; i <= NSTG; i++) begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
        // drop loads once they have written the store
        if (rdy[5]) begin
            vld_next[5] = vld_reg[4] && mode_reg[4];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = cz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            row_reg[0]   <= pgti_pkg::ROW_A_RST;
            row_reg[1]   <= pgti_pkg::ROW_B_RST;
            row_reg[2]   <= pgti_pkg::ROW_C_RST;
            cells_reg[0] <= pgti_pkg::CELL_BITS'(1);
            cells_reg[1] <= pgti_pkg::CELL_BITS'(1);
            cells_reg[2] <= pgti_pkg::CELL_BITS'(1);
        end else begin
            vld_reg <= vld_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    pgti_pkg::CFG_ROW_A:   row_reg[0] <= cfg_wdata;
                    pgti_pkg::CFG_ROW_B:   row_reg[1] <= cfg_wdata;
                    pgti_pkg::CFG_ROW_C:   row_reg[2] <= cfg_wdata;
                    pgti_pkg::CFG_CELLS_X: cells_reg[0] <= cfg_wdata[pgti_pkg::CELL_BITS-1:0];
                    pgti_pkg::CFG_CELLS_Y: cells_reg[1] <= cfg_wdata[pgti_pkg::CELL_BITS-1:0];
                    pgti_pkg::CFG_CELLS_Z: cells_reg[2] <= cfg_wdata[pgti_pkg::CELL_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload of stages 1..4 and carried offsets
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            mode_reg[1] <= s_tuser;
            ix_reg[1]   <= s_tdata[3:0];
            iy_reg[1]   <= s_tdata[7:4];
            iz_reg[1]   <= s_tdata[11:8];
            val_reg[1]  <= s_tdata[35:12];
            pos_reg[0]  <= s_tdata[36 +: PB];
            pos_reg[1]  <= s_tdata[60 +: PB];
            pos_reg[2]  <= s_tdata[84 +: PB];
        end
        for (int i = 2; i <= 4; i++) begin
            if (rdy[i]) begin
                mode_reg[i] <= mode_reg[i-1];
                ix_reg[i]   <= ix_reg[i-1];
                iy_reg[i]   <= iy_reg[i-1];
                iz_reg[i]   <= iz_reg[i-1];
                val_reg[i]  <= val_reg[i-1];
            end
        end
        if (rdy[5]) begin
            offy_reg[5] <= off[1];
            offz_reg[5] <= off[2];
        end
        for (int i = 6; i <= 7; i++) begin
            if (rdy[i]) begin
                offy_reg[i] <= offy_reg[i-1];
            end
        end
        for (int i = 6; i <= 9; i++) begin
            if (rdy[i]) begin
                offz_reg[i] <= offz_reg[i-1];
            end
        end
    end

    assign coord_en = '{prod: rdy[2], sum: rdy[3], scale: rdy[4]};

    for (genvar r = 0; r < 3; r++) begin : g_axis
        pgti_coord u_coord (
            .aclk  (aclk),
            .en    (coord_en),
            .pos   (pos_reg),
            .row   (row_reg[r]),
            .cells (cells_reg[r]),
            .idx   (idx[r]),
            .nxt   (nxt[r]),
            .off   (off[r]),
            .count (cnt[r])
        );
    end

    assign ram_we    = rdy[5] && vld_reg[4] && !mode_reg[4];
    assign ram_re    = rdy[5] && vld_reg[4] && mode_reg[4];
    assign ram_waddr = {ix_reg[4], iy_reg[4], iz_reg[4]};

    // corner j: bit 0 picks the upper x index, bit 1 y, bit 2 z
    for (genvar j = 0; j < 8; j++) begin : g_corner
        assign ram_raddr[j] = {(j % 2 == 1)       ? nxt[0] : idx[0],
                               ((j / 2) % 2 == 1) ? nxt[1] : idx[1],
                               (j / 4 == 1)       ? nxt[2] : idx[2]};
        pgti_ram u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (val_reg[4]),
            .re    (ram_re),
            .raddr (ram_raddr[j]),
            .rdata (corner[j])
        );
    end

    // blend along x, then y, then z
    assign lx_en = '{mul: rdy[6], fin: rdy[7]};
    assign ly_en = '{mul: rdy[8], fin: rdy[9]};
    assign lz_en = '{mul: rdy[10], fin: rdy[11]};

    logic [FB-1:0] offx_reg;
    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            offx_reg <= off[0];
        end
    end

    for (genvar p = 0; p < 4; p++) begin : g_lx
        pgti_lerp u_lerp (
            .aclk (aclk),
            .en   (lx_en),
            .a    (corner[2*p]),
            .b    (corner[2*p+1]),
            .f    (offx_reg),
            .y    (cx[p])
        );
    end

    for (genvar p = 0; p < 2; p++) begin : g_ly
        pgti_lerp u_lerp (
            .aclk (aclk),
            .en   (ly_en),
            .a    (cx[2*p]),
            .b    (cx[2*p+1]),
            .f    (offy_reg[7]),
            .y    (cy[p])
        );
    end

    pgti_lerp u_lz (
        .aclk (aclk),
        .en   (lz_en),
        .a    (cy[0]),
        .b    (cy[1]),
        .f    (offz_reg[9]),
        .y    (cz)
    );

    // input stall only when every stage is full and the receiver waits
    `ASSERT_CLK(a_stall_full, !s_tready |-> (&vld_reg) && !m_tready, "input stalled with room")
    `ASSERT_CLK(a_idx_range, vld_reg[4] && mode_reg[4] |-> {1'b0, idx[0]} < cnt[0], "x index out of range")
    `ASSERT_CLK(a_nxt_wrap, vld_reg[4] && mode_reg[4] && cnt[1] > 1 |-> nxt[1] != idx[1], "y upper corner equals lower")
    `ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule

[sv/pgti_ram.sv]
`timescale 1ns / 1ps
// One copy of the grid store: one write and one registered read per cycle.
// Depends on pgti_pkg.
module pgti_ram (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [pgti_pkg::ADDR_BITS-1:0]   waddr,
    input  logic [pgti_pkg::VALUE_BITS-1:0]  wdata,
    input  logic                             re,
    input  logic [pgti_pkg::ADDR_BITS-1:0]   raddr,
    output logic [pgti_pkg::VALUE_BITS-1:0]  rdata
);
    logic [pgti_pkg::VALUE_BITS-1:0] mem [pgti_pkg::GRID_DEPTH];
    logic [pgti_pkg::VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[sv/pgti_coord.sv]
`timescale 1ns / 1ps
// One axis of the coordinate pipe: matrix row times position, wrap, scale,
// split into cell index, next index and offset. Depends on pgti_pkg.
module pgti_coord (
    input  logic                             aclk,
    input  pgti_pkg::coord_en_t              en,
    input  pgti_pkg::pos_vec_t               pos,
    input  logic [pgti_pkg::ROW_BITS-1:0]    row,
    input  logic [pgti_pkg::CELL_BITS-1:0]   cells,
    output logic [pgti_pkg::IDX_BITS-1:0]    idx,
    output logic [pgti_pkg::IDX_BITS-1:0]    nxt,
    output logic [pgti_pkg::FRAC_BITS-1:0]   off,
    output logic [pgti_pkg::CELL_BITS-1:0]   count
);
    localparam int PROD_BITS  = pgti_pkg::POS_BITS + pgti_pkg::COEF_BITS;
    localparam int SCALE_BITS = pgti_pkg::WRAP_BITS + pgti_pkg::CELL_BITS;

    logic [2:0][pgti_pkg::WRAP_BITS-1:0] prod_reg, prod_next;
    logic [pgti_pkg::WRAP_BITS-1:0]      w_reg, w_next;
    logic [pgti_pkg::IDX_BITS-1:0]       idx_reg, idx_next, nxt_reg, nxt_next;
    logic [pgti_pkg::FRAC_BITS-1:0]      off_reg, off_next;
    logic [SCALE_BITS-1:0]               scaled;
    logic [pgti_pkg::CELL_BITS-1:0]      inc;
    logic signed [PROD_BITS-1:0]         full;

    assign count = pgti_pkg::cell_clamp(cells);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            full = $signed(pos[k]) *
                   $signed(row[k*pgti_pkg::COEF_BITS +: pgti_pkg::COEF_BITS]);
            // only the low bits survive the wrap into [0,1)
            prod_next[k] = full[pgti_pkg::WRAP_BITS-1:0];
        end
        w_next   = prod_reg[0] + prod_reg[1] + prod_reg[2];
        scaled   = SCALE_BITS'(w_reg) * SCALE_BITS'(count);
        idx_next = scaled[pgti_pkg::WRAP_BITS +: pgti_pkg::IDX_BITS];
        off_next = scaled[pgti_pkg::WRAP_BITS-1 -: pgti_pkg::FRAC_BITS];
        inc      = pgti_pkg::CELL_BITS'(idx_next) + pgti_pkg::CELL_BITS'(1);
        nxt_next = (inc >= count) ? '0 : inc[pgti_pkg::IDX_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.prod) begin
            prod_reg <= prod_next;
        end
        if (en.sum) begin
            w_reg <= w_next;
        end
        if (en.scale) begin
            idx_reg <= idx_next;
            nxt_reg <= nxt_next;
            off_reg <= off_next;
        end
    end

    assign idx = idx_reg;
    assign nxt = nxt_reg;
    assign off = off_reg;
endmodule

[sv/pgti_lerp.sv]
`timescale 1ns / 1ps
// Two-stage linear blend a + round((b - a) * f / 2^FRAC_BITS), rounding
// half away from zero. Depends on pgti_pkg.
module pgti_lerp (
    input  logic                                    aclk,
    input  pgti_pkg::lerp_en_t                      en,
    input  logic signed [pgti_pkg::VALUE_BITS-1:0]  a,
    input  logic signed [pgti_pkg::VALUE_BITS-1:0]  b,
    input  logic [pgti_pkg::FRAC_BITS-1:0]          f,
    output logic signed [pgti_pkg::VALUE_BITS-1:0]  y
);
    localparam int DIFF_BITS = pgti_pkg::VALUE_BITS + 1;
    localparam int MUL_BITS  = DIFF_BITS + pgti_pkg::FRAC_BITS;

    logic signed [DIFF_BITS-1:0]             diff;
    logic [DIFF_BITS-1:0]                    mag;
    logic signed [pgti_pkg::VALUE_BITS-1:0]  a_reg;
    logic                                    neg_reg;
    logic [MUL_BITS-1:0]                     prod_reg, prod_next;
    logic [MUL_BITS-1:0]                     rnd;
    logic signed [DIFF_BITS-1:0]             q, sum;
    logic signed [pgti_pkg::VALUE_BITS-1:0]  y_reg, y_next;

    always_comb begin
        diff      = DIFF_BITS'(b) - DIFF_BITS'(a);
        mag       = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
        prod_next = MUL_BITS'(mag) * MUL_BITS'(f);
        rnd       = prod_reg + (MUL_BITS'(1) << (pgti_pkg::FRAC_BITS - 1));
        q         = $signed(rnd[pgti_pkg::FRAC_BITS +: DIFF_BITS]);
        sum       = neg_reg ? (DIFF_BITS'(a_reg) - q) : (DIFF_BITS'(a_reg) + q);
        // result stays between a and b
        y_next    = sum[pgti_pkg::VALUE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            a_reg    <= a;
            neg_reg  <= diff[DIFF_BITS-1];
            prod_reg <= prod_next;
        end
        if (en.fin) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for periodic_grid_trilinear_interp: loads each cell box
// before it is queried, walks a directed table, then random loads and queries
// under several matrix and cell-count settings. Depends on pgti_pkg and the RTL.
module tb;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int PHASE_ITEMS     = 70;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct {
        logic        mode;
        logic [3:0]  ix, iy, iz;
        logic [23:0] value;
        logic [23:0] px, py, pz;
        bit          fixed;
        logic [23:0] fixed_val;
    } stim_row_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [111:0]                          s_tdata = '0;
    logic                                  s_tuser = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [pgti_pkg::VALUE_BITS-1:0]       m_tdata;
    logic                                  cfg_wr_en = 1'b0;
    logic [pgti_pkg::CFG_ADDR_BITS-1:0]    cfg_addr = '0;
    logic [pgti_pkg::ROW_BITS-1:0]         cfg_wdata = '0;

    // mirror of the block's state
    longint                                grid_mirror [pgti_pkg::GRID_DEPTH];
    bit                                    loaded [pgti_pkg::GRID_DEPTH];
    logic [pgti_pkg::ROW_BITS-1:0]         rows_mirror [3];
    logic [pgti_pkg::CELL_BITS-1:0]        cells_mirror [3];

    logic [pgti_pkg::VALUE_BITS-1:0]       pending_values [$];
    bit                                    quiet = 1'b0;
    int                                    errors = 0;
    int                                    queries_sent = 0;
    int                                    loads_sent = 0;
    int                                    results_seen = 0;
    int                                    idle_cycles = 0;
    int                                    stall_left = 0;

    periodic_grid_trilinear_interp dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint blend(input longint a, input longint b, input longint f);
        longint d, mag, q;
        d = b - a;
        mag = (d < 0) ? -d : d;
        q = (mag >>> pgti_pkg::FRAC_BITS) * f
            + (((mag & 65535) * f + 32768) >>> pgti_pkg::FRAC_BITS);
        return (d < 0) ? a - q : a + q;
    endfunction

    function automatic longint corner(input int x, input int y, input int z);
        return grid_mirror[(x * pgti_pkg::GRID_DIM + y) * pgti_pkg::GRID_DIM + z];
    endfunction

    function automatic logic [pgti_pkg::VALUE_BITS-1:0] interpolate(input logic [23:0] px,
            input logic [23:0] py, input logic [23:0] pz);
        longint pos [3];
        longint sum, n, c00, c10, c01, c11, c0, c1, res;
        logic [63:0] t;
        int lo [3];
        int hi [3];
        longint off [3];
        pos[0] = longint'($signed(px));
        pos[1] = longint'($signed(py));
        pos[2] = longint'($signed(pz));
        for (int r = 0; r < 3; r++) begin
            sum = 0;
            for (int k = 0; k < 3; k++)
                sum += pos[k] * longint'($signed(
                    rows_mirror[r][k*pgti_pkg::COEF_BITS +: pgti_pkg::COEF_BITS]));
            n = cells_mirror[r];
            if (n == 0) n = 1;
            if (n > pgti_pkg::GRID_DIM) n = pgti_pkg::GRID_DIM;
            // wrap into [0,1) by keeping the low fraction word
            t = {32'b0, sum[31:0]} * n;
            lo[r] = int'(t >> pgti_pkg::WRAP_BITS);
            off[r] = longint'(t[31:16]);
            hi[r] = (lo[r] + 1 >= n) ? 0 : lo[r] + 1;
        end
        c00 = blend(corner(lo[0], lo[1], lo[2]), corner(hi[0], lo[1], lo[2]), off[0]);
        c10 = blend(corner(lo[0], hi[1], lo[2]), corner(hi[0], hi[1], lo[2]), off[0]);
        c01 = blend(corner(lo[0], lo[1], hi[2]), corner(hi[0], lo[1], hi[2]), off[0]);
        c11 = blend(corner(lo[0], hi[1], hi[2]), corner(hi[0], hi[1], hi[2]), off[0]);
        c0 = blend(c00, c10, off[1]);
        c1 = blend(c01, c11, off[1]);
        res = blend(c0, c1, off[2]);
        return res[pgti_pkg::VALUE_BITS-1:0];
    endfunction

    task automatic send_word(input stim_row_t row);
        int a;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.mode;
        s_tdata  <= {4'b0, row.pz, row.py, row.px, row.value, row.iz, row.iy, row.ix};
        do @(posedge aclk); while (!s_tready);
        if (row.mode == MODE_QUERY) begin
            pending_values.push_back(row.fixed ? row.fixed_val
                                               : interpolate(row.px, row.py, row.pz));
            queries_sent++;
        end else begin
            a = (int'(row.ix) * pgti_pkg::GRID_DIM + int'(row.iy)) * pgti_pkg::GRID_DIM
                + int'(row.iz);
            grid_mirror[a] = longint'($signed(row.value));
            loaded[a] = 1'b1;
            loads_sent++;
        end
    endtask

    function automatic stim_row_t load_row(input int x, input int y, input int z,
            input logic [23:0] v);
        stim_row_t r;
        r = '{MODE_LOAD, 4'(x), 4'(y), 4'(z), v, 24'($urandom), 24'($urandom),
              24'($urandom), 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t query_row(input logic [23:0] px, input logic [23:0] py,
            input logic [23:0] pz, input bit fixed, input logic [23:0] v);
        stim_row_t r;
        r = '{MODE_QUERY, 4'($urandom), 4'($urandom), 4'($urandom), 24'($urandom),
              px, py, pz, fixed, v};
        return r;
    endfunction

    function automatic logic [23:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [pgti_pkg::COEF_BITS-1:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            default: return 18'($urandom);
        endcase
    endfunction

    // registers change only once the pipe has drained
    task automatic write_reg(input logic [pgti_pkg::CFG_ADDR_BITS-1:0] addr,
            input logic [pgti_pkg::ROW_BITS-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr <= pgti_pkg::CFG_ROW_C)
            rows_mirror[addr] = data;
        else
            cells_mirror[addr - pgti_pkg::CFG_CELLS_X] = data[pgti_pkg::CELL_BITS-1:0];
    endtask

    task automatic write_cells(input logic [pgti_pkg::CELL_BITS-1:0] nx,
            input logic [pgti_pkg::CELL_BITS-1:0] ny,
            input logic [pgti_pkg::CELL_BITS-1:0] nz);
        // upper bits are junk; only the low five count
        write_reg(pgti_pkg::CFG_CELLS_X, {49'($urandom), nx});
        write_reg(pgti_pkg::CFG_CELLS_Y, {49'($urandom), ny});
        write_reg(pgti_pkg::CFG_CELLS_Z, {49'($urandom), nz});
    endtask

    // load every entry of the cell box in use that holds no value yet
    task automatic fill_box();
        int n [3];
        for (int k = 0; k < 3; k++) begin
            n[k] = int'(cells_mirror[k]);
            if (n[k] == 0) n[k] = 1;
            if (n[k] > pgti_pkg::GRID_DIM) n[k] = pgti_pkg::GRID_DIM;
        end
        for (int x = 0; x < n[0]; x++)
            for (int y = 0; y < n[1]; y++)
                for (int z = 0; z < n[2]; z++)
                    if (!loaded[(x * pgti_pkg::GRID_DIM + y) * pgti_pkg::GRID_DIM + z])
                        send_word(load_row(x, y, z, 24'($urandom)));
    endtask

    // result side: random stall bursts, none at the tail of the run
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                logic [pgti_pkg::VALUE_BITS-1:0] want;
                want = pending_values.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: interp_value expected %h, actual %h", $time, want, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no word moved in %0d cycles", $time, WATCHDOG_CYCLES);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        stim_row_t directed [$];
        stim_row_t row;
        logic [pgti_pkg::CFG_ADDR_BITS-1:0] reg_idx;
        logic [pgti_pkg::CELL_BITS-1:0]     nc [3];
        rows_mirror[0] = pgti_pkg::ROW_A_RST;
        rows_mirror[1] = pgti_pkg::ROW_B_RST;
        rows_mirror[2] = pgti_pkg::ROW_C_RST;
        for (int k = 0; k < 3; k++) cells_mirror[k] = 5'd1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity matrix, one cell per axis: every query returns entry (0,0,0)
        directed.push_back(load_row(0, 0, 0, 24'h7fffff));
        directed.push_back(query_row(24'h0, 24'h0, 24'h0, 1'b1, 24'h7fffff));
        directed.push_back(query_row(24'h7fffff, 24'h800000, 24'h1, 1'b1, 24'h7fffff));
        directed.push_back(load_row(0, 0, 0, 24'h800000));
        directed.push_back(query_row(24'h800000, 24'h7fffff, 24'hffffff, 1'b1, 24'h800000));
        directed.push_back(load_row(15, 15, 15, 24'h0));
        directed.push_back(load_row(15, 0, 15, 24'hffffff));
        directed.push_back(load_row(0, 15, 0, 24'h7fffff));
        directed.push_back(query_row(24'h018000, 24'h7fffff, 24'h800000, 1'b0, '0));
        directed.push_back(load_row(0, 0, 0, 24'h0));
        directed.push_back(query_row(24'h038000, 24'h8000, 24'hff8000, 1'b1, 24'h0));
        directed.push_back(load_row(0, 0, 0, 24'd123456));
        directed.push_back(query_row(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b1, 24'd123456));
        foreach (directed[i]) send_word(directed[i]);

        // long x axis, then blend across upper-wrap corners
        write_cells(5'd16, 5'd2, 5'd2);
        fill_box();
        send_word(query_row(24'h0f8000, 24'h0fc000, 24'h0f4000, 1'b0, '0));
        send_word(query_row(24'h800000, 24'h7fffff, 24'h000001, 1'b0, '0));

        for (int phase = 0; phase < 6; phase++) begin
            // one axis may span the grid, the others stay short
            case (phase)
                0: write_cells(5'd16, 5'd2, 5'd2);
                1: write_cells(5'd0, 5'd31, 5'd1);
                2: write_cells(5'd1, 5'd2, 5'd17);
                default: begin
                    for (int k = 0; k < 3; k++) nc[k] = 5'($urandom_range(0, 2));
                    nc[$urandom_range(0, 2)] = 5'($urandom_range(0, 31));
                    write_cells(nc[0], nc[1], nc[2]);
                end
            endcase
            reg_idx = pgti_pkg::CFG_ROW_A;
            for (int r = 0; r < 3; r++) begin
                case (phase)
                    1: write_reg(reg_idx, {3{18'h1ffff}});
                    2: write_reg(reg_idx, {3{18'h20000}});
                    default: write_reg(reg_idx, {rand_coef(), rand_coef(), rand_coef()});
                endcase
                reg_idx++;
            end
            fill_box();
            quiet = (phase == 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 7)
                    row = query_row(rand_pos(), rand_pos(), rand_pos(), 1'b0, '0);
                else
                    row = load_row($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 15), 24'($urandom));
                send_word(row);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d loads and %0d queries over six register settings;",
                 loads_sent, queries_sent);
        $display("%0d results checked, %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
